// ----- rtl/bpa_pkg.sv -----
package bpa_pkg;

    localparam int OPERATION_W = 1;
    localparam int COUNT_W     = 13;
    localparam int ALIGN_W     = 13;
    localparam int START_W     = 12;
    localparam int STATUS_W    = 2;
    localparam int GRANT_W     = 12;
    localparam int LIMIT_W     = 13;
    localparam int WORD_BITS   = 64;

    typedef enum logic [OPERATION_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

endpackage

// ----- rtl/bpa_req_if.sv -----
interface bpa_req_if
    import bpa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OPERATION_W-1:0] operation;
    logic [COUNT_W-1:0]     page_count;
    logic [ALIGN_W-1:0]     alignment;
    logic [START_W-1:0]     start_page;

    modport source (output valid, operation, page_count, alignment, start_page, input ready);
    modport sink (input valid, operation, page_count, alignment, start_page, output ready);
endinterface

// ----- rtl/bpa_rsp_if.sv -----
interface bpa_rsp_if
    import bpa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_page;

    modport source (output valid, status, granted_page, input ready);
    modport sink (input valid, status, granted_page, output ready);
endinterface

// ----- rtl/bitmap_page_allocator_top.sv -----
// Channel  Dir  Handshake     Beat contents
// cfg      in   cfg_wr_en     cfg_wr_data: page_limit
// req      in   valid/ready   operation, page_count, alignment, start_page
// rsp      out  valid/ready   status, granted_page
//
// After reset a clearing pass marks every page taken, one bitmap word per cycle;
// req is not ready until it ends. An allocation walks the bitmap one page per cycle,
// pausing in a fetch state before each word; a taken page inside the candidate run
// moves the candidate start on by the alignment in a skip state until it lies past
// that page. Marking a run splits the start page into word and bit in the divider,
// then per word a fetch, a load, a step per page and a write. A free uses the same path.
// A finished result waits in the rsp register while the next beat is taken.
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int TOTAL_PAGES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    bpa_req_if.sink            req,
    bpa_rsp_if.source          rsp
);

    localparam int NUM_WORDS = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PAGE_W    = ($clog2(TOTAL_PAGES + 1) > LIMIT_W) ?
                               $clog2(TOTAL_PAGES + 1) : LIMIT_W;
    localparam int SUM_W     = PAGE_W + 2;

    typedef enum logic [10:0] {
        S_INIT   = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_FETCH  = 11'b00000000100,
        S_SCAN   = 11'b00000001000,
        S_SKIP   = 11'b00000010000,
        S_DIV    = 11'b00000100000,
        S_MFETCH = 11'b00001000000,
        S_MLOAD  = 11'b00010000000,
        S_MBIT   = 11'b00100000000,
        S_MWRITE = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [WADDR_W-1:0]   init_reg;
    logic [WADDR_W-1:0]   init_next;
    logic [PAGE_W-1:0]    limit_reg;
    logic [PAGE_W-1:0]    limit_next;
    op_t                  op_reg;
    op_t                  op_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [ALIGN_W-1:0]   align_reg;
    logic [ALIGN_W-1:0]   align_next;
    logic [SUM_W-1:0]     cand_reg;
    logic [SUM_W-1:0]     cand_next;
    logic [PAGE_W-1:0]    q_reg;
    logic [PAGE_W-1:0]    q_next;
    logic [WADDR_W-1:0]   word_reg;
    logic [WADDR_W-1:0]   word_next;
    logic [BIT_W-1:0]     bit_reg;
    logic [BIT_W-1:0]     bit_next;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   rem_next;
    logic [WORD_BITS-1:0] buf_reg;
    logic [WORD_BITS-1:0] buf_next;
    status_t              res_status_reg;
    status_t              res_status_next;
    logic [GRANT_W-1:0]   res_grant_reg;
    logic [GRANT_W-1:0]   res_grant_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    status_t              rsp_status_reg;
    status_t              rsp_status_next;
    logic [GRANT_W-1:0]   rsp_grant_reg;
    logic [GRANT_W-1:0]   rsp_grant_next;

    logic [PAGE_W-1:0]    eff_limit;
    logic [SUM_W-1:0]     run_end;
    logic [SUM_W-1:0]     free_end;
    logic                 page_free;
    logic                 last_bit;
    logic                 accept;

    logic                 div_start;
    logic [PAGE_W-1:0]    div_dividend;
    logic                 div_done;
    logic [PAGE_W-1:0]    div_quo;
    logic [BIT_W-1:0]     div_rem;

    logic                 ram_rd_en;
    logic                 ram_wr_en;
    logic [WADDR_W-1:0]   ram_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic [WORD_BITS-1:0] ram_rd_data;

    bpa_divider #(
        .DIVIDEND_W (PAGE_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    bpa_bitmap_ram #(
        .DEPTH  (NUM_WORDS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (WADDR_W)
    ) u_bitmap (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .wr_en   (ram_wr_en),
        .addr    (ram_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    assign eff_limit = (limit_reg > PAGE_W'(TOTAL_PAGES)) ? PAGE_W'(TOTAL_PAGES) : limit_reg;
    assign run_end   = cand_reg + SUM_W'(count_reg);
    assign free_end  = SUM_W'(req.start_page) + SUM_W'(req.page_count);
    assign page_free = ~ram_rd_data[bit_reg];
    assign last_bit  = bit_reg == BIT_W'(WORD_BITS - 1);
    assign accept    = req.valid && req.ready;

    assign req.ready = state_reg == S_IDLE;

    assign ram_rd_en   = (state_reg == S_FETCH) || (state_reg == S_MFETCH);
    assign ram_wr_en   = (state_reg == S_INIT) || (state_reg == S_MWRITE);
    assign ram_addr    = (state_reg == S_INIT) ? init_reg : word_reg;
    assign ram_wr_data = (state_reg == S_INIT) ? '1 : buf_reg;

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        limit_next      = limit_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        align_next      = align_reg;
        cand_next       = cand_reg;
        q_next          = q_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        buf_next        = buf_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_grant_next  = rsp_grant_reg;
        div_start       = 1'b0;
        div_dividend    = cand_reg[PAGE_W-1:0];

        if (cfg_wr_en)
        begin
            limit_next = PAGE_W'(cfg_wr_data);
        end

        case (state_reg)
            S_INIT:
            begin
                init_next = init_reg + 1'b1;
                if (init_reg == WADDR_W'(NUM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = op_t'(req.operation);
                    count_next     = req.page_count;
                    align_next     = (req.alignment == '0) ? ALIGN_W'(1) : req.alignment;
                    rem_next       = req.page_count;
                    res_status_next = ST_OK;
                    res_grant_next = '0;
                    if (op_t'(req.operation) == OP_ALLOC)
                    begin
                        cand_next  = '0;
                        q_next     = '0;
                        word_next  = '0;
                        bit_next   = '0;
                        state_next = S_FETCH;
                    end
                    else if (free_end > SUM_W'(eff_limit))
                    begin
                        res_status_next = ST_OUT_OF_RANGE;
                        state_next      = S_DONE;
                    end
                    else if (req.page_count == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = PAGE_W'(req.start_page);
                        state_next   = S_DIV;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN, S_SKIP:
            begin
                if ((state_reg == S_SCAN) && (run_end >= SUM_W'(eff_limit)))
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DONE;
                end
                else if ((state_reg == S_SCAN) && (count_reg == '0))
                begin
                    res_grant_next = cand_reg[GRANT_W-1:0];
                    state_next     = S_DONE;
                end
                else if ((state_reg == S_SCAN) && page_free
                         && (SUM_W'(q_reg) + 1'b1 == run_end))
                begin
                    res_grant_next = cand_reg[GRANT_W-1:0];
                    div_start      = 1'b1;
                    state_next     = S_DIV;
                end
                else if (((state_reg == S_SCAN) && !page_free && (cand_reg <= SUM_W'(q_reg)))
                         || ((state_reg == S_SKIP) && (cand_reg <= SUM_W'(q_reg))))
                begin
                    // Move the candidate start past the taken page.
                    if (state_reg == S_SKIP)
                    begin
                        cand_next = cand_reg + SUM_W'(align_reg);
                    end
                    state_next = S_SKIP;
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                    if (last_bit)
                    begin
                        bit_next   = '0;
                        word_next  = word_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    word_next  = div_quo[WADDR_W-1:0];
                    bit_next   = div_rem;
                    state_next = S_MFETCH;
                end
            end
            S_MFETCH:
            begin
                state_next = S_MLOAD;
            end
            S_MLOAD:
            begin
                buf_next   = ram_rd_data;
                state_next = S_MBIT;
            end
            S_MBIT:
            begin
                buf_next[bit_reg] = op_reg == OP_ALLOC;
                rem_next          = rem_reg - 1'b1;
                bit_next          = last_bit ? '0 : bit_reg + 1'b1;
                if (last_bit || (rem_reg == COUNT_W'(1)))
                begin
                    state_next = S_MWRITE;
                end
            end
            S_MWRITE:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = S_MFETCH;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_grant_next  = res_grant_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            limit_reg     <= PAGE_W'(TOTAL_PAGES);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            limit_reg     <= limit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        count_reg      <= count_next;
        align_reg      <= align_next;
        cand_reg       <= cand_next;
        q_reg          <= q_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        rem_reg        <= rem_next;
        buf_reg        <= buf_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        rsp_status_reg <= rsp_status_next;
        rsp_grant_reg  <= rsp_grant_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.granted_page = rsp_grant_reg;

endmodule

// ----- rtl/bpa_divider.sv -----
module bpa_divider
    import bpa_pkg::*;
#(
    parameter int DIVIDEND_W = 13
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DIVIDEND_W-1:0]          dividend,
    output logic                           done,
    output logic [DIVIDEND_W-1:0]          quotient,
    output logic [$clog2(WORD_BITS)-1:0]   remainder
);

    localparam int REM_W = $clog2(WORD_BITS);

    logic                  done_reg;
    logic                  done_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;

    // The word size is a power of two, so the split is a shift and a mask.
    always_comb
    begin
        done_next = start;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            quo_next = dividend >> REM_W;
            rem_next = dividend[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/bpa_bitmap_ram.sv -----
module bpa_bitmap_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wr_data,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
